>>> rtl/euler_xyz_rotation_matrix_defines.svh
// assertion macros for the euler xyz rotation matrix block
`ifndef EULER_XYZ_ROTATION_MATRIX_DEFINES_SVH
`define EULER_XYZ_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EXYZ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// response a fixed number of cycles after the trigger
`define EXYZ_ASSERT_LAT(lbl, trig, dly, resp, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> ##(dly) (resp)) \
		else $error(msg);

`endif

>>> rtl/exyz_rot_pkg.sv
// types and constants of the euler xyz rotation matrix block
package exyz_rot_pkg;

	typedef struct packed {
		logic signed [23:0] x_angle;
		logic signed [23:0] y_angle;
		logic signed [23:0] z_angle;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] x_axis_x;
		logic signed [15:0] x_axis_y;
		logic signed [15:0] x_axis_z;
		logic signed [15:0] y_axis_x;
		logic signed [15:0] y_axis_y;
		logic signed [15:0] y_axis_z;
		logic signed [15:0] z_axis_x;
		logic signed [15:0] z_axis_y;
		logic signed [15:0] z_axis_z;
	} axes_t;

	// angle unit inside the datapath is 2^-16 degree
	localparam int DEG_UNIT_BITS = 16;
	localparam int QUARTER = 90 << DEG_UNIT_BITS;
	localparam int CORDIC_STEPS = 16;

	// gain-compensated start value, q2.30
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// atan(2^-i) in 2^-16 degree
	localparam logic signed [25:0] ATAN_TAB [CORDIC_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
		26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
		26'sd917, 26'sd458, 26'sd229, 26'sd115
	};

endpackage

>>> rtl/euler_xyz_rotation_matrix.sv
// top level of the euler xyz rotation matrix block
//
// takes three angles (signed degrees, ANGLE_FRAC_BITS fraction bits) and
// returns R = Rx*Ry*Rz as its three columns in signed q1.RESULT_FRAC_BITS,
// saturated to +-1.0
//
// input channel: a beat is taken at a rising edge with start high and busy
// low; busy is held low, so a new beat may enter on every cycle
// output channel: done is high for exactly one cycle with the matrix on
// axes; the receiver cannot hold results off and none is needed
//
// registered stages from the accepting edge to the cycle done is high:
// angle reduction (reciprocal multiply, remainder, correction, quadrant
// split), sixteen cordic stages (one iteration per stage, one lane per
// angle), quadrant map and clamp, two product stages, term sum and
// final rounding
// throughput is one beat per cycle; the unrolled cordic sets the depth
// reset clears only the valid bits; the payload registers run free
`include "euler_xyz_rotation_matrix_defines.svh"

module euler_xyz_rotation_matrix #(
	parameter int RESULT_FRAC_BITS = 14,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  exyz_rot_pkg::angles_t  angles,
	output logic                   done,
	output exyz_rot_pkg::axes_t    axes
);
	import exyz_rot_pkg::*;

	// full turn in input units, reciprocal for the modulo, offset of the bias
	localparam int FULL = 360 << ANGLE_FRAC_BITS;
	localparam int RECIP = (1 << 24) / FULL;
	localparam int OFFS = (1 << 23) % FULL;
	localparam int UNIT_SHIFT = DEG_UNIT_BITS - ANGLE_FRAC_BITS;
	localparam int RND_SHIFT = 30 - RESULT_FRAC_BITS;
	localparam int LAT = 25;

	// two-factor product rounded back to q1.30
	function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		p = p + (64'sd1 <<< 29);
		return p[61:30];
	endfunction

	// round to the output fraction, saturate to +-1.0, keep 16 bits
	function automatic logic [15:0] finish(input logic signed [33:0] s);
		logic signed [35:0] v;
		logic signed [35:0] lim;
		v = s;
		lim = 36'sd1 <<< RESULT_FRAC_BITS;
		if (RND_SHIFT != 0) begin
			v = (v + (36'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
		end
		if (v > lim) begin
			v = lim;
		end else if (v < -lim) begin
			v = -lim;
		end
		return v[15:0];
	endfunction

	// a valid bit per stage, travelling with the data
	logic [LAT-1:0] vld_q;

	// lanes: 0 about x, 1 about y, 2 about z
	logic signed [23:0] ang [3];
	assign ang[0] = angles.x_angle;
	assign ang[1] = angles.y_angle;
	assign ang[2] = angles.z_angle;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	// s1: bias the angle to unsigned and multiply by the reciprocal of a turn
	logic [23:0] u_s1 [3];
	logic [40:0] prod_s1 [3];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			u_s1[l] <= {~ang[l][23], ang[l][22:0]};
			prod_s1[l] <= 41'({~ang[l][23], ang[l][22:0]}) * 41'(RECIP);
		end
	end

	// s2: remainder from the estimated quotient, below two turns
	logic [25:0] r_s2 [3];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			r_s2[l] <= 26'(41'(u_s1[l]) - 41'(prod_s1[l][40:24]) * 41'(FULL));
		end
	end

	// s3: one correction step, remove the bias, scale to 2^-16 degree
	logic [25:0] r1_c [3];
	logic signed [26:0] ad_c [3];
	logic [25:0] au_c [3];
	logic [24:0] a_s3 [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			r1_c[l] = (r_s2[l] >= 26'(FULL)) ? r_s2[l] - 26'(FULL) : r_s2[l];
			ad_c[l] = $signed({1'b0, r1_c[l]}) - 27'sd0 - 27'(OFFS);
			if (ad_c[l] < 0) begin
				ad_c[l] = ad_c[l] + 27'(FULL);
			end
			au_c[l] = ad_c[l][25:0] << UNIT_SHIFT;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			a_s3[l] <= au_c[l][24:0];
		end
	end

	// s4: quadrant and remainder inside the quadrant
	logic [1:0] quad_s4 [3];
	logic [22:0] rem_s4 [3];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (a_s3[l] >= 25'(3 * QUARTER)) begin
				quad_s4[l] <= 2'd3;
				rem_s4[l] <= 23'(a_s3[l] - 25'(3 * QUARTER));
			end else if (a_s3[l] >= 25'(2 * QUARTER)) begin
				quad_s4[l] <= 2'd2;
				rem_s4[l] <= 23'(a_s3[l] - 25'(2 * QUARTER));
			end else if (a_s3[l] >= 25'(QUARTER)) begin
				quad_s4[l] <= 2'd1;
				rem_s4[l] <= 23'(a_s3[l] - 25'(QUARTER));
			end else begin
				quad_s4[l] <= 2'd0;
				rem_s4[l] <= a_s3[l][22:0];
			end
		end
	end

	// s5..s20: cordic, one iteration per stage, quadrant carried alongside
	logic signed [33:0] cor_x_s [CORDIC_STEPS][3];
	logic signed [33:0] cor_y_s [CORDIC_STEPS][3];
	logic signed [25:0] cor_z_s [CORDIC_STEPS][3];
	logic [1:0] cor_q_s [CORDIC_STEPS][3];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
		logic signed [33:0] xi [3];
		logic signed [33:0] yi [3];
		logic signed [25:0] zi [3];
		logic [1:0] qi [3];

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					xi[l] = CORDIC_GAIN;
					yi[l] = '0;
					zi[l] = $signed({3'b000, rem_s4[l]});
					qi[l] = quad_s4[l];
				end
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					xi[l] = cor_x_s[k-1][l];
					yi[l] = cor_y_s[k-1][l];
					zi[l] = cor_z_s[k-1][l];
					qi[l] = cor_q_s[k-1][l];
				end
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				cor_q_s[k][l] <= qi[l];
				if (!zi[l][25]) begin
					cor_x_s[k][l] <= xi[l] - (yi[l] >>> k);
					cor_y_s[k][l] <= yi[l] + (xi[l] >>> k);
					cor_z_s[k][l] <= zi[l] - ATAN_TAB[k];
				end else begin
					cor_x_s[k][l] <= xi[l] + (yi[l] >>> k);
					cor_y_s[k][l] <= yi[l] - (xi[l] >>> k);
					cor_z_s[k][l] <= zi[l] + ATAN_TAB[k];
				end
			end
		end
	end

	// s21: rotate by the quadrant and clamp to +-1.0 in q1.30
	logic signed [33:0] c_c [3];
	logic signed [33:0] s_c [3];
	logic signed [31:0] cs_s21 [3];
	logic signed [31:0] sn_s21 [3];
	localparam logic signed [33:0] ONE30 = 34'sd1 <<< 30;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			case (cor_q_s[CORDIC_STEPS-1][l])
				2'd0: begin
					c_c[l] = cor_x_s[CORDIC_STEPS-1][l];
					s_c[l] = cor_y_s[CORDIC_STEPS-1][l];
				end
				2'd1: begin
					c_c[l] = -cor_y_s[CORDIC_STEPS-1][l];
					s_c[l] = cor_x_s[CORDIC_STEPS-1][l];
				end
				2'd2: begin
					c_c[l] = -cor_x_s[CORDIC_STEPS-1][l];
					s_c[l] = -cor_y_s[CORDIC_STEPS-1][l];
				end
				default: begin
					c_c[l] = cor_y_s[CORDIC_STEPS-1][l];
					s_c[l] = -cor_x_s[CORDIC_STEPS-1][l];
				end
			endcase
			if (c_c[l] > ONE30) begin
				c_c[l] = ONE30;
			end else if (c_c[l] < -ONE30) begin
				c_c[l] = -ONE30;
			end
			if (s_c[l] > ONE30) begin
				s_c[l] = ONE30;
			end else if (s_c[l] < -ONE30) begin
				s_c[l] = -ONE30;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			cs_s21[l] <= c_c[l][31:0];
			sn_s21[l] <= s_c[l][31:0];
		end
	end

	// s22: two-factor products, with sy, sz and cz carried along
	logic signed [31:0] sxsy_s22, cxsy_s22, cycz_s22, cxsz_s22, sxsz_s22;
	logic signed [31:0] cysz_s22, cxcz_s22, sxcz_s22, sxcy_s22, cxcy_s22;
	logic signed [31:0] sy_s22, sz_s22, cz_s22;

	always_ff @(posedge clk) begin
		sxsy_s22 <= mul30(sn_s21[0], sn_s21[1]);
		cxsy_s22 <= mul30(cs_s21[0], sn_s21[1]);
		cycz_s22 <= mul30(cs_s21[1], cs_s21[2]);
		cxsz_s22 <= mul30(cs_s21[0], sn_s21[2]);
		sxsz_s22 <= mul30(sn_s21[0], sn_s21[2]);
		cysz_s22 <= mul30(cs_s21[1], sn_s21[2]);
		cxcz_s22 <= mul30(cs_s21[0], cs_s21[2]);
		sxcz_s22 <= mul30(sn_s21[0], cs_s21[2]);
		sxcy_s22 <= mul30(sn_s21[0], cs_s21[1]);
		cxcy_s22 <= mul30(cs_s21[0], cs_s21[1]);
		sy_s22 <= sn_s21[1];
		sz_s22 <= sn_s21[2];
		cz_s22 <= cs_s21[2];
	end

	// s23: three-factor products from the rounded pairs
	logic signed [31:0] sxsycz_s23, cxsycz_s23, sxsysz_s23, cxsysz_s23;
	logic signed [31:0] cycz_s23, cxsz_s23, sxsz_s23, cysz_s23, cxcz_s23;
	logic signed [31:0] sxcz_s23, sxcy_s23, cxcy_s23, sy_s23;

	always_ff @(posedge clk) begin
		sxsycz_s23 <= mul30(sxsy_s22, cz_s22);
		cxsycz_s23 <= mul30(cxsy_s22, cz_s22);
		sxsysz_s23 <= mul30(sxsy_s22, sz_s22);
		cxsysz_s23 <= mul30(cxsy_s22, sz_s22);
		cycz_s23 <= cycz_s22;
		cxsz_s23 <= cxsz_s22;
		sxsz_s23 <= sxsz_s22;
		cysz_s23 <= cysz_s22;
		cxcz_s23 <= cxcz_s22;
		sxcz_s23 <= sxcz_s22;
		sxcy_s23 <= sxcy_s22;
		cxcy_s23 <= cxcy_s22;
		sy_s23 <= sy_s22;
	end

	// s24: exact sums of the terms, in matrix order
	logic signed [33:0] sum_s24 [9];

	always_ff @(posedge clk) begin
		sum_s24[0] <= 34'(cycz_s23);
		sum_s24[1] <= 34'(sxsycz_s23) + 34'(cxsz_s23);
		sum_s24[2] <= 34'(sxsz_s23) - 34'(cxsycz_s23);
		sum_s24[3] <= -34'(cysz_s23);
		sum_s24[4] <= 34'(cxcz_s23) - 34'(sxsysz_s23);
		sum_s24[5] <= 34'(cxsysz_s23) + 34'(sxcz_s23);
		sum_s24[6] <= 34'(sy_s23);
		sum_s24[7] <= -34'(sxcy_s23);
		sum_s24[8] <= 34'(cxcy_s23);
	end

	// s25: round, saturate, present with done
	always_ff @(posedge clk) begin
		axes.x_axis_x <= finish(sum_s24[0]);
		axes.x_axis_y <= finish(sum_s24[1]);
		axes.x_axis_z <= finish(sum_s24[2]);
		axes.y_axis_x <= finish(sum_s24[3]);
		axes.y_axis_y <= finish(sum_s24[4]);
		axes.y_axis_z <= finish(sum_s24[5]);
		axes.z_axis_x <= finish(sum_s24[6]);
		axes.z_axis_y <= finish(sum_s24[7]);
		axes.z_axis_z <= finish(sum_s24[8]);
	end

	assign done = vld_q[LAT-1];

	// every accepted beat comes out after the full pipeline depth
	`EXYZ_ASSERT_LAT(a_beat_out, start && !busy, LAT, done, "beat lost in pipeline")
	// a result only ever follows an accepted beat
	`EXYZ_ASSERT_IMP(a_no_spurious, done, $past(start, LAT), "result without a beat")
	// reduced x angle stays inside one turn
	`EXYZ_ASSERT_IMP(a_turn, vld_q[2], a_s3[0] < 25'(QUARTER * 4), "angle reduction out of range")
	// cordic start angle of the y lane stays inside one quadrant
	`EXYZ_ASSERT_IMP(a_quad, vld_q[3], rem_s4[1] < 23'(QUARTER), "quadrant split out of range")

endmodule
